>>> src/bofl_pkg.sv
// Shared types, constants and helper functions of the outline flattener.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package bofl_pkg;

    localparam int COORD_BITS = 24;
    localparam int PT_BITS    = 34;
    localparam int STEPS_W    = 7;
    localparam int MAX_STEPS  = 64;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd10;

    // Curve parameter t is a 0.16 number that can reach 1.0, so it needs 17 bits.
    localparam int T_W    = 17;
    localparam int TWON_W = STEPS_W + 1;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Bernstein weights are at most 2^48.
    localparam int W_W   = 49;
    localparam int SQ_W  = 33;
    localparam int ACC_W = 74;

    localparam logic [2:0] REQ_BEGIN = 3'd0;
    localparam logic [2:0] REQ_MOVE  = 3'd1;
    localparam logic [2:0] REQ_LINE  = 3'd2;
    localparam logic [2:0] REQ_CONIC = 3'd3;
    localparam logic [2:0] REQ_CUBIC = 3'd4;

    typedef struct packed {
        logic                 done;
        logic [T_W-1:0]       quot;
        logic [STEPS_W-1:0]   rem;
    } div_res_t;

    typedef struct packed {
        logic [T_W-1:0]    t;
        logic [TWON_W-1:0] r;
    } tpos_t;

    // Advances t = round(i * 65536 / n) to the next i, keeping the remainder of
    // (i * 131072 + n) / (2n) below 2n.
    function automatic tpos_t next_t(
        input logic [T_W-1:0]    t,
        input logic [TWON_W-1:0] r,
        input logic [T_W-1:0]    q_inc,
        input logic [TWON_W-1:0] r_inc,
        input logic [TWON_W-1:0] twon
    );
        logic [TWON_W:0] rs;
        tpos_t           res;
        rs = {1'b0, r} + {1'b0, r_inc};
        if (rs >= {1'b0, twon}) begin
            res.r = TWON_W'(rs - {1'b0, twon});
            res.t = t + q_inc + T_W'(1);
        end else begin
            res.r = rs[TWON_W-1:0];
            res.t = t + q_inc;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/bofl_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bofl_pkg for operand and product widths.
`default_nettype none

module bofl_mul (
    input  logic                                aclk,
    input  logic signed [bofl_pkg::MUL_A_W-1:0] a,
    input  logic signed [bofl_pkg::MUL_B_W-1:0] b,
    output logic signed [bofl_pkg::MUL_P_W-1:0] prod
);

    logic signed [bofl_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> src/bofl_div.sv
// Restoring divider that forms 65536 / n and its remainder, one bit per cycle.
// Depends on bofl_pkg for div_res_t and the widths.
`default_nettype none

module bofl_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bofl_pkg::STEPS_W-1:0]     divisor,
    output bofl_pkg::div_res_t               res
);

    localparam logic [4:0] TOP_BIT = 5'(bofl_pkg::T_W - 1);

    logic                           busy_reg;
    logic                           done_reg;
    logic [4:0]                     cnt_reg;
    logic [bofl_pkg::STEPS_W-1:0]   div_reg;
    logic [bofl_pkg::STEPS_W-1:0]   rem_reg;
    logic [bofl_pkg::T_W-1:0]       quot_reg;
    logic [bofl_pkg::STEPS_W:0]     shifted;
    logic                           ge;

    // The dividend 65536 has its only set bit at the top position.
    always_comb begin
        shifted = {rem_reg, (cnt_reg == TOP_BIT)};
        ge      = (shifted >= {1'b0, div_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg  <= TOP_BIT;
            div_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 5'd1;
            quot_reg <= {quot_reg[bofl_pkg::T_W-2:0], ge};
            if (ge) begin
                rem_reg <= bofl_pkg::STEPS_W'(shifted - {1'b0, div_reg});
            end else begin
                rem_reg <= shifted[bofl_pkg::STEPS_W-1:0];
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

`default_nettype wire

>>> src/bezier_outline_flattener_unit.sv
// Top level of the outline flattener: sequencer, point registers and accumulators.
// Depends on bofl_pkg, bofl_mul and bofl_div.
//
// Usage. The input channel (s_*) takes one path command word: begin outline,
// move-to, line-to, conic-to or cubic-to, with 18.6 coordinates. The result
// channel (m_*) gives point words in 1/65536 pixel, with new_contour, error and
// last flags; last marks the final word caused by a command. The user must write the
// steps register over cfg_wr_en/cfg_wr_data only while the block is idle; it is unchecked.
// Operation. The block works on one command at a time and s_ready is high
// only while it is idle. Begin outline and unknown codes give no word and leave
// the block idle. Move-to, line-to and a draw with no open contour give their
// single word in the cycle after acceptance. A curve first runs the divider
// (one quotient bit per cycle), then the multiplier sequence for each point:
// seven multiplies build the Bernstein weights and sixteen multiply weight
// halves by the control points, all on one 34x25 multiplier.
// Reset (aresetn low, synchronous) clears the pen point and the open-contour
// flag, sets steps to 10 and drops any word in flight. When the receiver stalls,
// the word waits in the output register and the sequencer holds.
`default_nettype none

module bezier_outline_flattener_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [bofl_pkg::STEPS_W-1:0]           cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [2:0]                             s_req_type,
    input  logic signed [bofl_pkg::COORD_BITS-1:0] s_ctrl1_x,
    input  logic signed [bofl_pkg::COORD_BITS-1:0] s_ctrl1_y,
    input  logic signed [bofl_pkg::COORD_BITS-1:0] s_ctrl2_x,
    input  logic signed [bofl_pkg::COORD_BITS-1:0] s_ctrl2_y,
    input  logic signed [bofl_pkg::COORD_BITS-1:0] s_to_x,
    input  logic signed [bofl_pkg::COORD_BITS-1:0] s_to_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bofl_pkg::PT_BITS-1:0]    m_point_x,
    output logic signed [bofl_pkg::PT_BITS-1:0]    m_point_y,
    output logic                                   m_new_contour,
    output logic                                   m_error,
    output logic                                   m_last
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_CALC = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    // Steps of the multiplier sequence for one point.
    localparam logic [4:0] SQ_UU     = 5'd0;
    localparam logic [4:0] SQ_TT     = 5'd1;
    localparam logic [4:0] SQ_UT     = 5'd2;
    localparam logic [4:0] SQ_U2U    = 5'd3;
    localparam logic [4:0] SQ_U2T    = 5'd4;
    localparam logic [4:0] SQ_T2U    = 5'd5;
    localparam logic [4:0] SQ_T2T    = 5'd6;
    localparam logic [4:0] SQ_W_BASE = 5'd7;
    localparam logic [4:0] SQ_FINAL  = 5'd24;

    localparam int CW = bofl_pkg::COORD_BITS;
    localparam int AW = bofl_pkg::ACC_W;
    localparam int PW = bofl_pkg::MUL_P_W;
    localparam int WW = bofl_pkg::W_W;
    localparam int QW = bofl_pkg::SQ_W;
    localparam int TW = bofl_pkg::T_W;
    localparam int NW = bofl_pkg::STEPS_W;
    localparam int HALF_W = 24;
    localparam int FRAC_SHIFT = 38;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (FRAC_SHIFT - 1);
    localparam logic [TW-1:0] T_ONE = TW'(1) << (TW - 1);

    state_t state_reg, state_next;

    logic [NW-1:0]            steps_reg;
    logic signed [CW-1:0]     cur_x_reg, cur_y_reg;
    logic                     open_reg;

    logic signed [CW-1:0]     px_reg [4];
    logic signed [CW-1:0]     py_reg [4];
    logic                     conic_reg;
    logic [NW-1:0]            n_reg;
    logic [NW-1:0]            i_reg;
    logic [4:0]               step_reg;
    logic [TW-1:0]            t_reg, q_inc_reg;
    logic [NW:0]              r_reg, r_inc_reg;
    logic [QW-1:0]            u2_reg, t2_reg, ut_reg;
    logic [WW-1:0]            u3_reg, u2t_reg, ut2_reg, t3_reg;
    logic signed [AW-1:0]     acc_x_reg, acc_y_reg;

    logic signed [bofl_pkg::PT_BITS-1:0] out_x_reg, out_y_reg;
    logic                     out_nc_reg, out_err_reg, out_last_reg;

    logic                     in_acc;
    logic                     is_curve;
    logic [NW-1:0]            n_eff;
    logic [NW:0]              twon;
    logic [TW-1:0]            u;
    logic [4:0]               wj, pj;
    logic [1:0]               wk;
    logic [WW-1:0]            w_sel;
    logic signed [CW-1:0]     p_sel;
    logic signed [bofl_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bofl_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]     prod;
    logic signed [AW-1:0]     addend;
    logic signed [AW-1:0]     sum_x, sum_y;
    logic                     div_start;
    bofl_pkg::div_res_t       div_res;
    bofl_pkg::tpos_t          tpos_first, tpos_more;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign in_acc  = s_valid && s_ready;
    assign is_curve = (s_req_type == bofl_pkg::REQ_CONIC) || (s_req_type == bofl_pkg::REQ_CUBIC);
    assign div_start = in_acc && is_curve && open_reg;

    // A zero step count acts as one, anything above the maximum as the maximum.
    always_comb begin
        if (steps_reg == '0) begin
            n_eff = NW'(1);
        end else if (steps_reg > NW'(bofl_pkg::MAX_STEPS)) begin
            n_eff = NW'(bofl_pkg::MAX_STEPS);
        end else begin
            n_eff = steps_reg;
        end
    end

    assign twon = {n_reg, 1'b0};
    assign u    = T_ONE - t_reg;

    assign tpos_first = bofl_pkg::next_t('0, {1'b0, n_reg}, div_res.quot,
                                         {div_res.rem, 1'b0}, twon);
    assign tpos_more  = bofl_pkg::next_t(t_reg, r_reg, q_inc_reg, r_inc_reg, twon);

    bofl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (n_eff),
        .res     (div_res)
    );

    // Weight selection: the index within the weight phase holds the coordinate
    // in bit 3, the weight number in bits 2:1 and the half in bit 0.
    assign wj = step_reg - SQ_W_BASE;
    assign wk = wj[2:1];

    always_comb begin
        if (conic_reg) begin
            unique case (wk)
                2'd0:    w_sel = {u2_reg, 16'd0};
                2'd1:    w_sel = {ut_reg[QW-2:0], 17'd0};
                2'd2:    w_sel = {t2_reg, 16'd0};
                default: w_sel = '0;
            endcase
        end else begin
            unique case (wk)
                2'd0:    w_sel = u3_reg;
                2'd1:    w_sel = u2t_reg + {u2t_reg[WW-2:0], 1'b0};
                2'd2:    w_sel = ut2_reg + {ut2_reg[WW-2:0], 1'b0};
                default: w_sel = t3_reg;
            endcase
        end
        p_sel = wj[3] ? py_reg[wk] : px_reg[wk];
    end

    always_comb begin
        unique case (step_reg)
            SQ_UU: begin
                mul_a = bofl_pkg::MUL_A_W'(u);
                mul_b = bofl_pkg::MUL_B_W'(u);
            end
            SQ_TT: begin
                mul_a = bofl_pkg::MUL_A_W'(t_reg);
                mul_b = bofl_pkg::MUL_B_W'(t_reg);
            end
            SQ_UT: begin
                mul_a = bofl_pkg::MUL_A_W'(u);
                mul_b = bofl_pkg::MUL_B_W'(t_reg);
            end
            SQ_U2U: begin
                mul_a = bofl_pkg::MUL_A_W'(u2_reg);
                mul_b = bofl_pkg::MUL_B_W'(u);
            end
            SQ_U2T: begin
                mul_a = bofl_pkg::MUL_A_W'(u2_reg);
                mul_b = bofl_pkg::MUL_B_W'(t_reg);
            end
            SQ_T2U: begin
                mul_a = bofl_pkg::MUL_A_W'(t2_reg);
                mul_b = bofl_pkg::MUL_B_W'(u);
            end
            SQ_T2T: begin
                mul_a = bofl_pkg::MUL_A_W'(t2_reg);
                mul_b = bofl_pkg::MUL_B_W'(t_reg);
            end
            default: begin
                // Even index: low 24 bits of the weight, odd: the high 25 bits.
                mul_a = wj[0] ? bofl_pkg::MUL_A_W'(w_sel[WW-1:HALF_W])
                              : bofl_pkg::MUL_A_W'(w_sel[HALF_W-1:0]);
                mul_b = {p_sel[CW-1], p_sel};
            end
        endcase
    end

    bofl_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // The product in hand belongs to the previous step.
    assign pj = step_reg - SQ_W_BASE - 5'd1;

    always_comb begin
        if (pj[0]) begin
            addend = {{(AW - PW){prod[PW-1]}}, prod} <<< HALF_W;
        end else begin
            addend = {{(AW - PW){prod[PW-1]}}, prod};
        end
        sum_x = acc_x_reg + ROUND_HALF;
        sum_y = acc_y_reg + ROUND_HALF;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_req_type == bofl_pkg::REQ_MOVE || s_req_type == bofl_pkg::REQ_LINE) begin
                        state_next = ST_OUT;
                    end else if (is_curve) begin
                        state_next = open_reg ? ST_DIV : ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (step_reg == SQ_FINAL) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = out_last_reg ? ST_IDLE : ST_CALC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            steps_reg <= bofl_pkg::STEPS_RESET;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            open_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                steps_reg <= cfg_wr_data;
            end
            if (in_acc) begin
                if (s_req_type == bofl_pkg::REQ_BEGIN) begin
                    cur_x_reg <= '0;
                    cur_y_reg <= '0;
                    open_reg  <= 1'b0;
                end else if (s_req_type == bofl_pkg::REQ_MOVE) begin
                    cur_x_reg <= s_to_x;
                    cur_y_reg <= s_to_y;
                    open_reg  <= 1'b1;
                end else if ((s_req_type == bofl_pkg::REQ_LINE || is_curve) && open_reg) begin
                    cur_x_reg <= s_to_x;
                    cur_y_reg <= s_to_y;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_last_reg <= 1'b1;
            if (s_req_type == bofl_pkg::REQ_MOVE) begin
                out_x_reg   <= {s_to_x, 10'd0};
                out_y_reg   <= {s_to_y, 10'd0};
                out_nc_reg  <= 1'b1;
                out_err_reg <= 1'b0;
            end else if (s_req_type == bofl_pkg::REQ_LINE && open_reg) begin
                out_x_reg   <= {s_to_x, 10'd0};
                out_y_reg   <= {s_to_y, 10'd0};
                out_nc_reg  <= 1'b0;
                out_err_reg <= 1'b0;
            end else begin
                // Any other command loads a zero point, with the error flag set when no contour is open.
                out_x_reg   <= '0;
                out_y_reg   <= '0;
                out_nc_reg  <= 1'b0;
                out_err_reg <= !open_reg;
            end
            // The pen point becomes the first control point of a curve.
            px_reg[0] <= cur_x_reg;
            py_reg[0] <= cur_y_reg;
            px_reg[1] <= s_ctrl1_x;
            py_reg[1] <= s_ctrl1_y;
            if (s_req_type == bofl_pkg::REQ_CONIC) begin
                px_reg[2] <= s_to_x;
                py_reg[2] <= s_to_y;
                px_reg[3] <= '0;
                py_reg[3] <= '0;
            end else begin
                px_reg[2] <= s_ctrl2_x;
                py_reg[2] <= s_ctrl2_y;
                px_reg[3] <= s_to_x;
                py_reg[3] <= s_to_y;
            end
            conic_reg <= (s_req_type == bofl_pkg::REQ_CONIC);
            n_reg     <= n_eff;
        end

        if (state_reg == ST_DIV && div_res.done) begin
            q_inc_reg <= div_res.quot;
            r_inc_reg <= {div_res.rem, 1'b0};
            t_reg     <= tpos_first.t;
            r_reg     <= tpos_first.r;
            i_reg     <= NW'(1);
            step_reg  <= '0;
        end

        if (state_reg == ST_OUT && m_ready && !out_last_reg) begin
            t_reg    <= tpos_more.t;
            r_reg    <= tpos_more.r;
            i_reg    <= i_reg + NW'(1);
            step_reg <= '0;
        end

        if (state_reg == ST_CALC) begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == SQ_UU) begin
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            unique case (step_reg - 5'd1)
                SQ_UU:  u2_reg  <= prod[QW-1:0];
                SQ_TT:  t2_reg  <= prod[QW-1:0];
                SQ_UT:  ut_reg  <= prod[QW-1:0];
                SQ_U2U: u3_reg  <= prod[WW-1:0];
                SQ_U2T: u2t_reg <= prod[WW-1:0];
                SQ_T2U: ut2_reg <= prod[WW-1:0];
                SQ_T2T: t3_reg  <= prod[WW-1:0];
                default: begin
                    if (step_reg > SQ_W_BASE && step_reg < SQ_FINAL) begin
                        if (pj[3]) begin
                            acc_y_reg <= acc_y_reg + addend;
                        end else begin
                            acc_x_reg <= acc_x_reg + addend;
                        end
                    end
                end
            endcase
            if (step_reg == SQ_FINAL) begin
                out_x_reg    <= sum_x[FRAC_SHIFT + bofl_pkg::PT_BITS - 1:FRAC_SHIFT];
                out_y_reg    <= sum_y[FRAC_SHIFT + bofl_pkg::PT_BITS - 1:FRAC_SHIFT];
                out_nc_reg   <= 1'b0;
                out_err_reg  <= 1'b0;
                out_last_reg <= (i_reg == n_reg);
            end
        end
    end

    assign m_point_x     = out_x_reg;
    assign m_point_y     = out_y_reg;
    assign m_new_contour = out_nc_reg;
    assign m_error       = out_err_reg;
    assign m_last        = out_last_reg;

`ifndef SYNTHESIS
    // The block never takes a command while a word waits to be delivered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("command accepted while a word is pending");

    // An error word is always the only and therefore final word of its command.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_last && !m_new_contour))
        else $error("error word is not marked last");

    // The point counter stays within the latched step count during a curve.
    a_point_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (step_reg <= SQ_FINAL && i_reg >= NW'(1) && i_reg <= n_reg))
        else $error("curve sequencer out of range");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for bezier_outline_flattener_unit: directed and random path commands.
// It predicts every point word and compares it with the DUT output.
// Depends on bofl_pkg and the RTL of the flattener only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Request codes 5 to 7 are not defined, and the block must ignore them.
    localparam logic [2:0] REQ_UNDEF_A = 3'd5;
    localparam logic [2:0] REQ_UNDEF_B = 3'd6;
    localparam logic [2:0] REQ_UNDEF_C = 3'd7;

    // Longest stretch with no word moved on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 4000;

    typedef logic signed [bofl_pkg::COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [2:0] req;
        coord_t     c1x, c1y, c2x, c2y, tx, ty;
    } path_cmd_t;

    typedef struct packed {
        logic [bofl_pkg::PT_BITS-1:0] px;
        logic [bofl_pkg::PT_BITS-1:0] py;
        logic                         nc;
        logic                         err;
        logic                         last;
    } point_word_t;

    typedef struct packed {
        path_cmd_t   cmd;
        logic        typed;
        point_word_t want;
    } dir_row_t;

    typedef longint unsigned weight_vec_t[4];
    typedef coord_t          coord_vec_t[4];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [bofl_pkg::STEPS_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_req_type = '0;
    coord_t s_ctrl1_x = '0, s_ctrl1_y = '0, s_ctrl2_x = '0, s_ctrl2_y = '0;
    coord_t s_to_x = '0, s_to_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [bofl_pkg::PT_BITS-1:0] m_point_x, m_point_y;
    logic m_new_contour, m_error, m_last;

    always #1 aclk = ~aclk;

    bezier_outline_flattener_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_ctrl1_x     (s_ctrl1_x),
        .s_ctrl1_y     (s_ctrl1_y),
        .s_ctrl2_x     (s_ctrl2_x),
        .s_ctrl2_y     (s_ctrl2_y),
        .s_to_x        (s_to_x),
        .s_to_y        (s_to_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_new_contour (m_new_contour),
        .m_error       (m_error),
        .m_last        (m_last)
    );

    // Predictor state: the pen point, the open-contour flag and the steps register.
    coord_t pen_x = '0, pen_y = '0;
    bit contour_open = 1'b0;
    logic [bofl_pkg::STEPS_W-1:0] steps_reg = bofl_pkg::STEPS_RESET;

    point_word_t pending_points[$];
    int mismatch_count = 0;
    bit no_idle = 1'b0;
    int quiet_cycles = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Exact weighted sum of four 18.6 points, rounded half up from 2^-54 to 2^-16 pixel.
    // The weights add up to 2^48, so the sum carries 48 + 6 fractional bits.
    function automatic logic [bofl_pkg::PT_BITS-1:0] bernstein_sum(input weight_vec_t w,
                                                                   input coord_vec_t p);
        logic signed [79:0] acc, wk, pk;
        acc = '0;
        for (int k = 0; k < 4; k++) begin
            wk = w[k];
            pk = p[k];
            acc = acc + wk * pk;
        end
        acc = (acc + (80'sd1 <<< 37)) >>> 38;
        return acc[bofl_pkg::PT_BITS-1:0];
    endfunction

    // Works out the point words that one accepted command causes and queues them.
    task automatic flatten_command(input path_cmd_t c);
        point_word_t pw;
        weight_vec_t w;
        coord_vec_t px, py;
        longint unsigned n, t, u;
        logic signed [bofl_pkg::PT_BITS-1:0] sx, sy;
        case (c.req)
            bofl_pkg::REQ_BEGIN: begin
                pen_x = '0;
                pen_y = '0;
                contour_open = 1'b0;
            end
            bofl_pkg::REQ_MOVE, bofl_pkg::REQ_LINE: begin
                if (c.req == bofl_pkg::REQ_LINE && !contour_open) begin
                    pending_points.push_back('{px: '0, py: '0, nc: 1'b0, err: 1'b1,
                                               last: 1'b1});
                end else begin
                    // An 18.6 coordinate becomes 1/65536 pixel by a factor of 1024.
                    sx = bofl_pkg::PT_BITS'(c.tx) <<< 10;
                    sy = bofl_pkg::PT_BITS'(c.ty) <<< 10;
                    pending_points.push_back('{px: sx, py: sy,
                                               nc: (c.req == bofl_pkg::REQ_MOVE),
                                               err: 1'b0, last: 1'b1});
                    contour_open = 1'b1;
                    pen_x = c.tx;
                    pen_y = c.ty;
                end
            end
            bofl_pkg::REQ_CONIC, bofl_pkg::REQ_CUBIC: begin
                if (!contour_open) begin
                    pending_points.push_back('{px: '0, py: '0, nc: 1'b0, err: 1'b1,
                                               last: 1'b1});
                end else begin
                    // A steps value of 0 acts as 1 and values above the maximum saturate.
                    n = (steps_reg == 0) ? 1 :
                        (steps_reg > bofl_pkg::MAX_STEPS) ? bofl_pkg::MAX_STEPS : steps_reg;
                    px[0] = pen_x;
                    py[0] = pen_y;
                    px[1] = c.c1x;
                    py[1] = c.c1y;
                    if (c.req == bofl_pkg::REQ_CONIC) begin
                        px[2] = c.tx;
                        py[2] = c.ty;
                        px[3] = '0;
                        py[3] = '0;
                    end else begin
                        px[2] = c.c2x;
                        py[2] = c.c2y;
                        px[3] = c.tx;
                        py[3] = c.ty;
                    end
                    for (longint unsigned i = 1; i <= n; i++) begin
                        t = (i * 131072 + n) / (2 * n);
                        u = 65536 - t;
                        if (c.req == bofl_pkg::REQ_CONIC) begin
                            w[0] = (u * u) << 16;
                            w[1] = (2 * u * t) << 16;
                            w[2] = (t * t) << 16;
                            w[3] = 0;
                        end else begin
                            w[0] = u * u * u;
                            w[1] = 3 * u * u * t;
                            w[2] = 3 * u * t * t;
                            w[3] = t * t * t;
                        end
                        pw.px = bernstein_sum(w, px);
                        pw.py = bernstein_sum(w, py);
                        pw.nc = 1'b0;
                        pw.err = 1'b0;
                        pw.last = (i == n);
                        pending_points.push_back(pw);
                    end
                    pen_x = c.tx;
                    pen_y = c.ty;
                end
            end
            default: ;
        endcase
    endtask

    // Drives one command word, with an optional idle burst first, and waits for
    // the handshake. The expected words are queued at the accepting edge.
    task automatic send_command(input path_cmd_t c, input bit typed, input point_word_t want);
        @(negedge aclk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_req_type <= c.req;
        s_ctrl1_x <= c.c1x;
        s_ctrl1_y <= c.c1y;
        s_ctrl2_x <= c.c2x;
        s_ctrl2_y <= c.c2y;
        s_to_x <= c.tx;
        s_to_y <= c.ty;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        flatten_command(c);
        // Rows with a hand-typed answer replace the single predicted word.
        if (typed) begin
            void'(pending_points.pop_back());
            pending_points.push_back(want);
        end
    endtask

    // Lets the block finish all queued words and settle before a register write.
    task automatic drain_and_write_steps(input logic [bofl_pkg::STEPS_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (8) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        steps_reg = value;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0, 1: return coord_t'($urandom);
            2: return $urandom_range(0, 1) ? coord_t'(24'h7FFFFF) : coord_t'(24'h800000);
            default: return coord_t'($urandom_range(0, 16383)) - coord_t'(8192);
        endcase
    endfunction

    function automatic path_cmd_t rand_command();
        path_cmd_t c;
        int pick;
        c.c1x = rand_coord();
        c.c1y = rand_coord();
        c.c2x = rand_coord();
        c.c2y = rand_coord();
        c.tx = rand_coord();
        c.ty = rand_coord();
        pick = $urandom_range(0, 99);
        // Mostly well-formed drawing inside an open contour; some noise and restarts.
        if (!contour_open && pick < 80)
            c.req = bofl_pkg::REQ_MOVE;
        else if (pick < 6)
            c.req = bofl_pkg::REQ_BEGIN;
        else if (pick < 9)
            c.req = 3'($urandom_range(REQ_UNDEF_A, REQ_UNDEF_C));
        else if (pick < 18)
            c.req = bofl_pkg::REQ_MOVE;
        else if (pick < 40)
            c.req = bofl_pkg::REQ_LINE;
        else if (pick < 70)
            c.req = bofl_pkg::REQ_CONIC;
        else
            c.req = bofl_pkg::REQ_CUBIC;
        return c;
    endfunction

    // Result side: random stall bursts, none in the last phase.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    // Output checker: every word moved is compared with the oldest expectation.
    always @(posedge aclk) begin
        point_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report("unexpected word, point_x", m_point_x, 0);
            end else begin
                want = pending_points.pop_front();
                if (m_point_x !== want.px) report("point_x", m_point_x, want.px);
                if (m_point_y !== want.py) report("point_y", m_point_y, want.py);
                if (m_new_contour !== want.nc) report("new_contour", m_new_contour, want.nc);
                if (m_error !== want.err) report("error", m_error, want.err);
                if (m_last !== want.last) report("last", m_last, want.last);
            end
        end
    end

    // Watchdog: a long run of cycles with no word moved on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    dir_row_t directed[17];
    logic [bofl_pkg::STEPS_W-1:0] phase_steps[7] =
        '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd10, 7'd7};

    initial begin
        point_word_t no_word;
        path_cmd_t c;
        int sent;
        no_word = '0;
        // Opcode, ctrl1 x/y, ctrl2 x/y, end x/y, then the typed answer where one is obvious.
        directed[0]  = '{'{bofl_pkg::REQ_BEGIN, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
                         0, '0};
        // Drawing before any move-to is an error with a zero point.
        directed[1]  = '{'{bofl_pkg::REQ_LINE, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                           24'sd100, 24'sd100},
                         1, '{'0, '0, 1'b0, 1'b1, 1'b1}};
        directed[2]  = '{'{bofl_pkg::REQ_CONIC, 24'sd5, 24'sd5, 24'sd0, 24'sd0, 24'sd9, 24'sd9},
                         1, '{'0, '0, 1'b0, 1'b1, 1'b1}};
        directed[3]  = '{'{bofl_pkg::REQ_CUBIC, 24'sd5, 24'sd5, 24'sd7, 24'sd7, 24'sd9, 24'sd9},
                         1, '{'0, '0, 1'b0, 1'b1, 1'b1}};
        // Undefined codes produce nothing.
        directed[4]  = '{'{REQ_UNDEF_A, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1}, 0, '0};
        directed[5]  = '{'{REQ_UNDEF_B, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1}, 0, '0};
        directed[6]  = '{'{REQ_UNDEF_C, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd1}, 0, '0};
        directed[7]  = '{'{bofl_pkg::REQ_MOVE, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                           24'sh7FFFFF, 24'sh800000},
                         1, '{34'h1FFFFFC00, 34'h200000000, 1'b1, 1'b0, 1'b1}};
        directed[8]  = '{'{bofl_pkg::REQ_LINE, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                           24'sh800000, 24'sh7FFFFF},
                         1, '{34'h200000000, 34'h1FFFFFC00, 1'b0, 1'b0, 1'b1}};
        directed[9]  = '{'{bofl_pkg::REQ_CONIC, 24'sh7FFFFF, 24'sh7FFFFF, 24'sd0, 24'sd0,
                           24'sh800000, 24'sh800000}, 0, '0};
        directed[10] = '{'{bofl_pkg::REQ_CUBIC, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
                           24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF}, 0, '0};
        directed[11] = '{'{bofl_pkg::REQ_LINE, 24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd1, -24'sd1},
                         1, '{34'h3FFFFFC00, 34'h3FFFFFC00, 1'b0, 1'b0, 1'b1}};
        directed[12] = '{'{bofl_pkg::REQ_CUBIC, 24'sd0, 24'sd0, -24'sd1, -24'sd1, 24'sd0, 24'sd0},
                         0, '0};
        directed[13] = '{'{bofl_pkg::REQ_BEGIN, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
                         0, '0};
        // Begin outline closes the contour, so drawing is an error again.
        directed[14] = '{'{bofl_pkg::REQ_CONIC, 24'sd64, 24'sd64, 24'sd0, 24'sd0, 24'sd3, 24'sd3},
                         1, '{'0, '0, 1'b0, 1'b1, 1'b1}};
        directed[15] = '{'{bofl_pkg::REQ_MOVE, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
                         1, '{'0, '0, 1'b1, 1'b0, 1'b1}};
        directed[16] = '{'{bofl_pkg::REQ_CONIC, 24'sd64, -24'sd64, 24'sd0, 24'sd0,
                           24'sd128, 24'sd0}, 0, '0};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[r])
            send_command(directed[r].cmd, directed[r].typed, directed[r].want);

        // Random phases, each at its own steps setting; draining before each write
        // also makes the sender wait for every outstanding word.
        sent = 0;
        foreach (phase_steps[ph]) begin
            drain_and_write_steps(phase_steps[ph]);
            no_idle = (ph == 6);
            for (int k = 0; k < 19; ) begin
                c = rand_command();
                send_command(c, 1'b0, no_word);
                if (c.req <= bofl_pkg::REQ_CUBIC) k++;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        wait (pending_points.size() == 0);
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> bezier_outline_flattener_unit.f
src/bofl_pkg.sv
src/bofl_mul.sv
src/bofl_div.sv
src/bezier_outline_flattener_unit.sv
sim/tb.sv
